/* design/mlrc_pkg.sv */
// Shared types and constants for the midpoint line rasteriser with clipping.
// Depends on nothing; imported by midpoint_line_raster_clip.
package mlrc_pkg;

  // Coordinate width of every endpoint, pixel and clip bound.
  localparam int COORD_BITS = 12;

  // Request action codes.
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_CLIP_LEFT   = 2'd0;
  localparam logic [1:0] REG_CLIP_RIGHT  = 2'd1;
  localparam logic [1:0] REG_CLIP_BOTTOM = 2'd2;
  localparam logic [1:0] REG_CLIP_TOP    = 2'd3;

  typedef struct packed {
    logic                          action;
    logic signed [COORD_BITS-1:0]  start_x;
    logic signed [COORD_BITS-1:0]  start_y;
    logic signed [COORD_BITS-1:0]  end_x;
    logic signed [COORD_BITS-1:0]  end_y;
  } line_req_t;

  typedef struct packed {
    logic                          pixel_valid;
    logic signed [COORD_BITS-1:0]  pixel_x;
    logic signed [COORD_BITS-1:0]  pixel_y;
    logic                          pixel_visible;
    logic                          line_done;
  } pixel_t;

endpackage

/* design/midpoint_line_raster_clip.sv */
// Midpoint line rasteriser with per-pixel clip flag, top level.
// Depends on mlrc_pkg for the request and pixel types and the codes.
//
// Usage:
//  - Request channel (req_valid / req_stall / req): a START request loads both
//    endpoints and returns the start pixel; each ADVANCE request moves one
//    pixel along the current line and returns it. An ADVANCE with no line in
//    progress returns a result with pixel_valid low and all fields zero.
//  - Result channel (pix_valid / pix_stall / pix): exactly one result for
//    every accepted request, in request order.
//  - The result is registered: a request taken at one edge shows its result
//    from the next edge. One request is taken every cycle while req_stall is
//    low; the single add and compare of the decision update sets that rate.
//  - The result register parts the two sides: a new request is taken while
//    the result register is empty or its result is being taken in the same
//    cycle. While the receiver stalls a waiting result, req_stall is raised
//    and the result holds.
//  - Reset clears the line state, empties the result register and loads the
//    clip bounds with 0..799 in x and 0..599 in y. Write the clip bounds
//    through cfg_write_en / cfg_index / cfg_data while the block is idle.
module midpoint_line_raster_clip
  import mlrc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [1:0]             cfg_index,
  input  logic [COORD_BITS-1:0]  cfg_data,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  line_req_t              req,
  output logic                   pix_valid,
  input  logic                   pix_stall,
  output pixel_t                 pix
);

  localparam int N    = COORD_BITS;
  localparam int DECW = COORD_BITS + 4;

  // Slope regions.
  localparam logic [1:0] REGION_STEEP_DOWN   = 2'd0;
  localparam logic [1:0] REGION_SHALLOW_DOWN = 2'd1;
  localparam logic [1:0] REGION_SHALLOW_UP   = 2'd2;
  localparam logic [1:0] REGION_STEEP_UP     = 2'd3;

  // Sign-extend a coordinate difference to decision width.
  function automatic logic signed [DECW-1:0] to_dec(input logic signed [N:0] v);
    return $signed({{(DECW-N-1){v[N]}}, v});
  endfunction

  // Clip bounds.
  logic signed [N-1:0] clip_left;
  logic signed [N-1:0] clip_right;
  logic signed [N-1:0] clip_bottom;
  logic signed [N-1:0] clip_top;

  // Line state.
  logic signed [N-1:0]  cur_x, cur_x_next;
  logic signed [N-1:0]  cur_y, cur_y_next;
  logic signed [N:0]    delta_x, delta_x_next;
  logic signed [N:0]    delta_y, delta_y_next;
  logic signed [DECW-1:0] decision, decision_next;
  logic [N:0]           steps_left, steps_left_next;
  logic [1:0]           slope_region, slope_region_next;
  logic                 reverse_dir, reverse_dir_next;
  logic                 line_active, line_active_next;

  logic   req_take;
  pixel_t pix_next;

  // Start set-up terms.
  logic signed [N:0]   sa, sb, neg_a, neg_b, half_a, half_b;
  logic [N-1:0]        abs_a, abs_b;
  logic                a_neg, b_neg, a_zero, b_zero, b_pos;
  logic                in_r0, in_r1, in_r2, in_r3;

  // Advance terms.
  logic signed [1:0]      step_dx, step_dy;
  logic signed [DECW-1:0] step_dd;
  logic                   dec_neg, dec_zero;

  logic done;

  // Take a request while the result register is free or draining.
  assign req_stall = pix_valid && pix_stall;
  assign req_take  = req_valid && !req_stall;

  // Differences of the endpoints, one bit wider so they never wrap.
  assign sa = $signed({req.end_y[N-1], req.end_y}) - $signed({req.start_y[N-1], req.start_y});
  assign sb = $signed({req.end_x[N-1], req.end_x}) - $signed({req.start_x[N-1], req.start_x});
  assign neg_a  = -sa;
  assign neg_b  = -sb;
  assign a_neg  = sa[N];
  assign b_neg  = sb[N];
  assign a_zero = (sa == '0);
  assign b_zero = (sb == '0);
  assign b_pos  = !b_neg && !b_zero;
  assign abs_a  = a_neg ? neg_a[N-1:0] : sa[N-1:0];
  assign abs_b  = b_neg ? neg_b[N-1:0] : sb[N-1:0];
  // Halve with truncation toward zero: bias negatives by one before the shift.
  assign half_a = (sa + $signed({{N{1'b0}}, a_neg})) >>> 1;
  assign half_b = (sb + $signed({{N{1'b0}}, b_neg})) >>> 1;

  // Region tests on exact integers, no slope division.
  assign in_r0 = (b_zero && a_neg) || (b_pos && (sa <= neg_b)) || (b_neg && (sa >= neg_b));
  assign in_r1 = !b_zero && (a_zero || ((a_neg != b_neg) && (abs_a < abs_b)));
  assign in_r2 = !b_zero && !a_zero && (abs_a <= abs_b);
  assign in_r3 = !a_zero;

  assign dec_neg  = decision[DECW-1];
  assign dec_zero = (decision == '0);

  // Per-region step: move and decision increment before direction reversal.
  always_comb begin
    step_dx = 2'sd0;
    step_dy = 2'sd0;
    step_dd = '0;
    case (slope_region)
      REGION_STEEP_DOWN: begin
        if (!dec_neg) begin
          step_dy = -2'sd1;
          step_dd = -to_dec(delta_x);
        end else begin
          step_dx = 2'sd1;
          step_dy = -2'sd1;
          step_dd = -to_dec(delta_y) - to_dec(delta_x);
        end
      end
      REGION_SHALLOW_DOWN: begin
        if (!dec_neg) begin
          step_dx = 2'sd1;
          step_dd = to_dec(delta_y);
        end else begin
          step_dx = 2'sd1;
          step_dy = -2'sd1;
          step_dd = to_dec(delta_y) + to_dec(delta_x);
        end
      end
      REGION_SHALLOW_UP: begin
        if (dec_neg || dec_zero) begin
          step_dx = 2'sd1;
          step_dd = to_dec(delta_y);
        end else begin
          step_dx = 2'sd1;
          step_dy = 2'sd1;
          step_dd = to_dec(delta_y) - to_dec(delta_x);
        end
      end
      default: begin
        if (dec_neg || dec_zero) begin
          step_dy = 2'sd1;
          step_dd = to_dec(delta_x);
        end else begin
          step_dx = 2'sd1;
          step_dy = 2'sd1;
          step_dd = to_dec(delta_x) - to_dec(delta_y);
        end
      end
    endcase
    // Walk backwards when the line was given right to left.
    if (reverse_dir) begin
      step_dx = -step_dx;
      step_dy = -step_dy;
      step_dd = -step_dd;
    end
  end

  // Next line state and the result for the request on the port.
  always_comb begin
    cur_x_next        = cur_x;
    cur_y_next        = cur_y;
    delta_x_next      = delta_x;
    delta_y_next      = delta_y;
    decision_next     = decision;
    steps_left_next   = steps_left;
    slope_region_next = slope_region;
    reverse_dir_next  = reverse_dir;
    line_active_next  = line_active;
    done              = 1'b0;

    if (req.action == ACT_START) begin
      // Load a new line; any line in progress is dropped.
      cur_x_next       = req.start_x;
      cur_y_next       = req.start_y;
      delta_x_next     = sb;
      delta_y_next     = sa;
      reverse_dir_next = (req.start_x > req.end_x);
      if (in_r0) begin
        slope_region_next = REGION_STEEP_DOWN;
        decision_next     = -to_dec(sb) - to_dec(half_a);
        steps_left_next   = {1'b0, abs_a};
      end else if (in_r1) begin
        slope_region_next = REGION_SHALLOW_DOWN;
        decision_next     = to_dec(sa) + to_dec(half_b);
        steps_left_next   = {1'b0, abs_b};
      end else if (in_r2) begin
        slope_region_next = REGION_SHALLOW_UP;
        decision_next     = to_dec(sa) - to_dec(half_b);
        steps_left_next   = {1'b0, abs_b};
      end else if (in_r3) begin
        slope_region_next = REGION_STEEP_UP;
        decision_next     = to_dec(sb) - to_dec(half_a);
        steps_left_next   = {1'b0, abs_a};
      end else begin
        // Zero-length line: start pixel only.
        slope_region_next = REGION_STEEP_DOWN;
        decision_next     = '0;
        steps_left_next   = '0;
      end
      line_active_next = (steps_left_next != '0);
      done             = !line_active_next;
    end else if (line_active) begin
      // Advance one pixel; coordinates wrap at the coordinate width.
      cur_x_next       = cur_x + N'(step_dx);
      cur_y_next       = cur_y + N'(step_dy);
      decision_next    = decision + step_dd;
      steps_left_next  = steps_left - 1'b1;
      line_active_next = (steps_left_next != '0);
      done             = !line_active_next;
    end

    pix_next = '0;
    if (req.action == ACT_START || line_active) begin
      pix_next.pixel_valid   = 1'b1;
      pix_next.pixel_x       = cur_x_next;
      pix_next.pixel_y       = cur_y_next;
      pix_next.pixel_visible = (cur_x_next >= clip_left) && (cur_x_next <= clip_right) &&
                               (cur_y_next >= clip_bottom) && (cur_y_next <= clip_top);
      pix_next.line_done     = done;
    end
  end

  // Clip bounds, line state and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left    <= N'(0);
      clip_right   <= N'(799);
      clip_bottom  <= N'(0);
      clip_top     <= N'(599);
      cur_x        <= '0;
      cur_y        <= '0;
      delta_x      <= '0;
      delta_y      <= '0;
      decision     <= '0;
      steps_left   <= '0;
      slope_region <= REGION_STEEP_DOWN;
      reverse_dir  <= 1'b0;
      line_active  <= 1'b0;
      pix_valid    <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          REG_CLIP_LEFT:   clip_left   <= $signed(cfg_data);
          REG_CLIP_RIGHT:  clip_right  <= $signed(cfg_data);
          REG_CLIP_BOTTOM: clip_bottom <= $signed(cfg_data);
          REG_CLIP_TOP:    clip_top    <= $signed(cfg_data);
          default: ;
        endcase
      end
      if (req_take) begin
        cur_x        <= cur_x_next;
        cur_y        <= cur_y_next;
        delta_x      <= delta_x_next;
        delta_y      <= delta_y_next;
        decision     <= decision_next;
        steps_left   <= steps_left_next;
        slope_region <= slope_region_next;
        reverse_dir  <= reverse_dir_next;
        line_active  <= line_active_next;
        pix_valid    <= 1'b1;
      end else if (!pix_stall) begin
        // Drop the result once the receiver has taken it.
        pix_valid <= 1'b0;
      end
    end
  end

  // Result payload: load on a taken request, hold otherwise.
  always_ff @(posedge clk) begin
    if (req_take) begin
      pix <= pix_next;
    end
  end

endmodule
